/* design/srsr_pkg.sv */
// Shared package for the stable record sort ranker.
// Holds the store size, the field widths and the record type that the front,
// queue and back modules use. It depends on nothing.
package srsr_pkg;

  // Store capacity. The block is built for any value from 2 to 31.
  localparam int MaxRecords = 16;

  // Depth of the queue between the front and back parts. It is a power of two.
  localparam int QueueDepth = 4;

  // Field widths.
  localparam int IdW   = 10;
  localparam int TimeW = 16;
  localparam int RankW = 5;

  // Derived widths: the store index and a count that can hold MaxRecords itself.
  localparam int IdxW  = $clog2(MaxRecords);
  localparam int CntW  = $clog2(MaxRecords + 1);
  localparam int QPtrW = $clog2(QueueDepth);

  // One classified record as it travels from the front to the back.
  typedef struct packed {
    logic [IdW-1:0]   id;
    logic [TimeW-1:0] time_key;
    logic             set_end;
    logic             keep;     // 0 when the store is already full
  } rec_t;

  // Queue status as the front and back see it.
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

/* design/srsr_front.sv */
// Front part of the stable record sort ranker: accepts input transactions and
// classifies each record as kept or dropped against the store capacity.
// Depends on srsr_pkg.
module srsr_front import srsr_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  logic [IdW-1:0]   athlete_id_i,
  input  logic [TimeW-1:0] time_tenths_i,
  input  logic             set_end_i,
  input  q_status_t        q_status_i,
  output logic             push_o,
  output rec_t             rec_o
);

  logic [CntW-1:0] cnt_q, cnt_d;
  logic            keep;

  // The block stalls the sender only while the queue is full.
  assign busy   = q_status_i.full;
  assign push_o = start && !q_status_i.full;

  // A record is kept while fewer than a full store are counted in this set.
  assign keep = (cnt_q < CntW'(MaxRecords));

  assign rec_o.id       = athlete_id_i;
  assign rec_o.time_key = time_tenths_i;
  assign rec_o.set_end  = set_end_i;
  assign rec_o.keep     = keep;

  // Count of kept records in the current set; a closing record restarts it.
  always_comb begin
    cnt_d = cnt_q;
    if (push_o) begin
      if (set_end_i) begin
        cnt_d = '0;
      end else if (keep) begin
        cnt_d = cnt_q + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

endmodule

/* design/srsr_queue.sv */
// Short queue of classified records between the front and back parts.
// Depends on srsr_pkg for the record type and the depth.
module srsr_queue import srsr_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  rec_t      rec_i,
  input  logic      pop_i,
  output rec_t      rec_o,
  output q_status_t status_o
);

  rec_t            mem_q [QueueDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QPtrW:0]   fill_q, fill_d;
  logic             do_push, do_pop;

  assign status_o.full  = (fill_q == (QPtrW+1)'(QueueDepth));
  assign status_o.empty = (fill_q == '0);

  assign do_push = push_i && !status_o.full;
  assign do_pop  = pop_i && !status_o.empty;

  assign rec_o = mem_q[rd_ptr_q];

  // Fill level follows pushes and pops.
  always_comb begin
    fill_d = fill_q;
    if (do_push && !do_pop) begin
      fill_d = fill_q + (QPtrW+1)'(1);
    end else if (do_pop && !do_push) begin
      fill_d = fill_q - (QPtrW+1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      fill_q <= fill_d;
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + QPtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + QPtrW'(1);
      end
    end
  end

  // Queue entries carry payload only.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= rec_i;
    end
  end

endmodule

/* design/srsr_back.sv */
// Back part of the stable record sort ranker: loads records from the queue,
// sorts them by odd-even transposition and shifts out the ranked results.
// Depends on srsr_pkg.
module srsr_back import srsr_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  q_status_t        q_status_i,
  input  rec_t             rec_i,
  output logic             pop_o,
  output logic             result_valid_o,
  output logic [RankW-1:0] rank_o,
  output logic [IdW-1:0]   out_id_o,
  output logic [TimeW-1:0] out_time_o,
  output logic             last_result_o,
  output logic             overflowed_o
);

  localparam logic [1:0] StLoad = 2'd0;
  localparam logic [1:0] StSort = 2'd1;
  localparam logic [1:0] StEmit = 2'd2;

  logic [1:0]       state_q, state_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [CntW-1:0]  emit_q, emit_d;
  logic [IdxW-1:0]  pass_q, pass_d;
  logic             drop_q, drop_d;
  logic             last;
  logic [CntW+RankW-1:0] rank_wide;

  logic [TimeW-1:0] key_q [MaxRecords];
  logic [TimeW-1:0] key_d [MaxRecords];
  logic [IdW-1:0]   id_q  [MaxRecords];
  logic [IdW-1:0]   id_d  [MaxRecords];

  assign pop_o = (state_q == StLoad) && !q_status_i.empty;
  assign last  = ((emit_q + CntW'(1)) == cnt_q);

  // Results come straight from the head of the store.
  assign rank_wide      = (CntW+RankW)'(emit_q) + (CntW+RankW)'(1);
  assign result_valid_o = (state_q == StEmit);
  assign rank_o         = rank_wide[RankW-1:0];
  assign out_id_o       = id_q[0];
  assign out_time_o     = key_q[0];
  assign last_result_o  = (state_q == StEmit) && last;
  assign overflowed_o   = drop_q;

  // Sequencer: load until a closing record, sort a fixed number of passes,
  // then emit one ranked record per cycle.
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    emit_d  = emit_q;
    pass_d  = pass_q;
    drop_d  = drop_q;
    unique case (state_q)
      StLoad: begin
        if (pop_o) begin
          if (rec_i.keep) begin
            cnt_d = cnt_q + CntW'(1);
          end else begin
            drop_d = 1'b1;
          end
          if (rec_i.set_end) begin
            state_d = StSort;
            pass_d  = '0;
          end
        end
      end
      StSort: begin
        pass_d = pass_q + IdxW'(1);
        if (pass_q == IdxW'(MaxRecords - 1)) begin
          state_d = StEmit;
          emit_d  = '0;
        end
      end
      StEmit: begin
        emit_d = emit_q + CntW'(1);
        if (last) begin
          state_d = StLoad;
          cnt_d   = '0;
          drop_d  = 1'b0;
        end
      end
      default: begin
        state_d = StLoad;
      end
    endcase
  end

  // Store datapath: write at the fill position, compare-swap neighbor pairs
  // of one parity per sort cycle, or shift toward the head while emitting.
  // Only held entries swap, and only on a greater key; equal keys never pass.
  always_comb begin
    key_d = key_q;
    id_d  = id_q;
    unique case (state_q)
      StLoad: begin
        if (pop_o && rec_i.keep) begin
          key_d[cnt_q[IdxW-1:0]] = rec_i.time_key;
          id_d[cnt_q[IdxW-1:0]]  = rec_i.id;
        end
      end
      StSort: begin
        for (int k = 0; k < MaxRecords - 1; k++) begin
          if ((((k & 1) == 1) == pass_q[0]) && (CntW'(k + 1) < cnt_q) &&
              (key_q[k] > key_q[k+1])) begin
            key_d[k]   = key_q[k+1];
            key_d[k+1] = key_q[k];
            id_d[k]    = id_q[k+1];
            id_d[k+1]  = id_q[k];
          end
        end
      end
      StEmit: begin
        for (int k = 0; k < MaxRecords - 1; k++) begin
          key_d[k] = key_q[k+1];
          id_d[k]  = id_q[k+1];
        end
      end
      default: begin
        key_d = key_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StLoad;
      cnt_q   <= '0;
      emit_q  <= '0;
      pass_q  <= '0;
      drop_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      emit_q  <= emit_d;
      pass_q  <= pass_d;
      drop_q  <= drop_d;
    end
  end

  // The record store holds payload only.
  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    id_q  <= id_d;
  end

endmodule

/* design/stable_record_sort_ranker.sv */
// Top level of the stable record sort ranker: front classifier, record queue
// and sorting back part. Depends on srsr_pkg, srsr_front, srsr_queue, srsr_back.
//
//   channel   handshake                 payload
//   --------  ------------------------  ---------------------------------------
//   records   start, busy               athlete_id_i, time_tenths_i, set_end_i
//   results   result_valid_o (strobe)   rank_o, out_id_o, out_time_o,
//                                       last_result_o, overflowed_o
//
// A record transaction is taken at any edge with start high and busy low; busy
// rises only while the four-entry queue is full.
// While loading, the back part moves one record per cycle from the queue into
// the store when the queue holds one. A closing record starts the odd-even sort
// passes over the store, after which the n held records leave one per cycle.
// Records of the next set wait in the queue meanwhile.
// Reset is asynchronous and empties the queue and the store count.
// Each result is shown for one cycle only; the receiver cannot stall.
module stable_record_sort_ranker import srsr_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  logic [IdW-1:0]   athlete_id_i,
  input  logic [TimeW-1:0] time_tenths_i,
  input  logic             set_end_i,
  output logic             result_valid_o,
  output logic [RankW-1:0] rank_o,
  output logic [IdW-1:0]   out_id_o,
  output logic [TimeW-1:0] out_time_o,
  output logic             last_result_o,
  output logic             overflowed_o
);

  q_status_t q_status;
  rec_t      front_rec, back_rec;
  logic      push, pop;

  srsr_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .athlete_id_i  (athlete_id_i),
    .time_tenths_i (time_tenths_i),
    .set_end_i     (set_end_i),
    .q_status_i    (q_status),
    .push_o        (push),
    .rec_o         (front_rec)
  );

  srsr_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .rec_i    (front_rec),
    .pop_i    (pop),
    .rec_o    (back_rec),
    .status_o (q_status)
  );

  srsr_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_status_i     (q_status),
    .rec_i          (back_rec),
    .pop_o          (pop),
    .result_valid_o (result_valid_o),
    .rank_o         (rank_o),
    .out_id_o       (out_id_o),
    .out_time_o     (out_time_o),
    .last_result_o  (last_result_o),
    .overflowed_o   (overflowed_o)
  );

endmodule

/* design/srsr_checker.sv */
// Port-level checker for the stable record sort ranker, bound to the top level.
// Depends on srsr_pkg for the field widths.
module srsr_checker import srsr_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             result_valid_o,
  input logic [RankW-1:0] rank_o,
  input logic [TimeW-1:0] out_time_o,
  input logic             last_result_o,
  input logic             overflowed_o
);

  // The final mark only comes with a result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_result_o |-> result_valid_o)
    else $error("last_result_o without a result");

  // A set always starts at rank one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(result_valid_o) |-> (rank_o == RankW'(1)))
    else $error("first result of a set not ranked one");

  // Results of a set follow each other with rising rank.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !last_result_o) |=>
      (result_valid_o && (rank_o == RankW'($past(rank_o) + RankW'(1)))))
    else $error("rank sequence broken within a set");

  // Times never decrease within a set.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !last_result_o) |=> (out_time_o >= $past(out_time_o)))
    else $error("results not in ascending time order");

  // The overflow flag holds across a set.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !last_result_o) |=> (overflowed_o == $past(overflowed_o)))
    else $error("overflow flag changed within a set");

endmodule

bind stable_record_sort_ranker srsr_checker u_srsr_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .result_valid_o (result_valid_o),
  .rank_o         (rank_o),
  .out_time_o     (out_time_o),
  .last_result_o  (last_result_o),
  .overflowed_o   (overflowed_o)
);

/* test/stable_record_sort_ranker_tb.sv */
`timescale 1ns / 1ps
// Testbench for stable_record_sort_ranker: it loads record sets, predicts the stable
// ascending ranking of each set and checks every result strobe against it.
// Depends on srsr_pkg and the stable_record_sort_ranker design files.
module stable_record_sort_ranker_tb;
  import srsr_pkg::*;

  localparam int CycleLimit = 200000;
  localparam int DrainCycles = 60;

  // One ranked record as the block should emit it.
  typedef struct packed {
    logic [RankW-1:0] rank;
    logic [IdW-1:0]   id;
    logic [TimeW-1:0] time_key;
    logic             last;
    logic             overflow;
  } ranked_rec_t;

  // Ranking predictor: it keeps its own copy of the record store and queues the
  // ranked records that each closing transaction should produce.
  class rank_scoreboard;
    logic [TimeW-1:0] key_mem [MaxRecords];
    logic [IdW-1:0]   id_mem  [MaxRecords];
    int               held;
    bit               dropped;
    ranked_rec_t      pending_ranks[$];
    int               mismatches;

    function new();
      held = 0;
      dropped = 0;
      mismatches = 0;
    endfunction

    // Note one accepted record transaction.
    function void note_record(logic [IdW-1:0] id, logic [TimeW-1:0] key, logic closing);
      logic [TimeW-1:0] keys [MaxRecords];
      logic [IdW-1:0]   ids  [MaxRecords];
      logic [TimeW-1:0] tk;
      logic [IdW-1:0]   ti;
      ranked_rec_t      rec;
      if (held < MaxRecords) begin
        key_mem[held] = key;
        id_mem[held] = id;
        held++;
      end else begin
        dropped = 1'b1;
      end
      if (!closing) return;
      for (int k = 0; k < held; k++) begin
        keys[k] = key_mem[k];
        ids[k] = id_mem[k];
      end
      // Bubble sort that swaps only on a strictly greater key keeps ties in order.
      for (int pass = 0; pass + 1 < held; pass++) begin
        for (int k = 0; k + 1 < held - pass; k++) begin
          if (keys[k] > keys[k+1]) begin
            tk = keys[k];
            ti = ids[k];
            keys[k] = keys[k+1];
            ids[k] = ids[k+1];
            keys[k+1] = tk;
            ids[k+1] = ti;
          end
        end
      end
      for (int k = 0; k < held; k++) begin
        rec.rank = RankW'(k + 1);
        rec.id = ids[k];
        rec.time_key = keys[k];
        rec.last = (k + 1 == held);
        rec.overflow = dropped;
        pending_ranks.push_back(rec);
      end
      held = 0;
      dropped = 1'b0;
    endfunction

    // Compare one result strobe with the oldest expected ranked record.
    function void check_ranked(logic [RankW-1:0] rank, logic [IdW-1:0] id,
                               logic [TimeW-1:0] time_key, logic last, logic overflow);
      ranked_rec_t exp_rec;
      if (pending_ranks.size() == 0) begin
        $error("result with no expected record: rank %0d id %0d time %0d", rank, id,
               time_key);
        mismatches++;
        return;
      end
      exp_rec = pending_ranks.pop_front();
      if (rank !== exp_rec.rank) begin
        $error("rank: expected %0d, actual %0d", exp_rec.rank, rank);
        mismatches++;
      end
      if (id !== exp_rec.id) begin
        $error("out_id: expected %0d, actual %0d", exp_rec.id, id);
        mismatches++;
      end
      if (time_key !== exp_rec.time_key) begin
        $error("out_time: expected %0d, actual %0d", exp_rec.time_key, time_key);
        mismatches++;
      end
      if (last !== exp_rec.last) begin
        $error("last_result: expected %0d, actual %0d", exp_rec.last, last);
        mismatches++;
      end
      if (overflow !== exp_rec.overflow) begin
        $error("overflowed: expected %0d, actual %0d", exp_rec.overflow, overflow);
        mismatches++;
      end
    endfunction
  endclass

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             start = 1'b0;
  logic             busy;
  logic [IdW-1:0]   athlete_id_i = '0;
  logic [TimeW-1:0] time_tenths_i = '0;
  logic             set_end_i = 1'b0;
  logic             result_valid_o;
  logic [RankW-1:0] rank_o;
  logic [IdW-1:0]   out_id_o;
  logic [TimeW-1:0] out_time_o;
  logic             last_result_o;
  logic             overflowed_o;

  rank_scoreboard ranks;
  int             cycle_count = 0;

  stable_record_sort_ranker i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .athlete_id_i  (athlete_id_i),
    .time_tenths_i (time_tenths_i),
    .set_end_i     (set_end_i),
    .result_valid_o(result_valid_o),
    .rank_o        (rank_o),
    .out_id_o      (out_id_o),
    .out_time_o    (out_time_o),
    .last_result_o (last_result_o),
    .overflowed_o  (overflowed_o)
  );

  // Clock with a 10 ns period.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Every result strobe is checked at the edge that ends its cycle.
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      ranks.check_ranked(rank_o, out_id_o, out_time_o, last_result_o, overflowed_o);
    end
  end

  // Cycle limit guards against a hung block.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Drive one record transaction, with random idle cycles ahead of it.
  task automatic send_record(logic [IdW-1:0] id, logic [TimeW-1:0] key, logic closing,
                             int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      athlete_id_i <= IdW'($urandom);
      time_tenths_i <= TimeW'($urandom);
      set_end_i <= 1'($urandom);
      @(posedge clk_i);
    end
    start <= 1'b1;
    athlete_id_i <= id;
    time_tenths_i <= key;
    set_end_i <= closing;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    ranks.note_record(id, key, closing);
  endtask

  // Keys drawn in several styles so that ties and extremes show up often.
  function automatic logic [TimeW-1:0] pick_key(int mode);
    case (mode)
      0: return TimeW'($urandom);
      1: return TimeW'($urandom_range(3));
      2: return ($urandom_range(1) != 0) ? {TimeW{1'b1}} : '0;
      default: return TimeW'($urandom_range(1200, 1100));
    endcase
  endfunction

  // Random record sets, mostly short, some full and some past capacity.
  task automatic run_random_sets(int goal, int idle_pct);
    int sent;
    int len;
    int mode;
    int pick;
    sent = 0;
    while (sent < goal) begin
      pick = $urandom_range(9);
      if (pick < 6) len = $urandom_range(6, 1);
      else if (pick < 8) len = $urandom_range(MaxRecords, 7);
      else len = $urandom_range(MaxRecords + 4, MaxRecords + 1);
      mode = $urandom_range(3);
      for (int i = 0; i < len; i++) begin
        send_record(IdW'($urandom), pick_key(mode), (i == len - 1), idle_pct);
      end
      sent += len;
    end
  endtask

  initial begin
    int idle_plan [3];
    idle_plan = '{0, 83, 24};
    ranks = new();

    // Hold reset low, then release it.
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // A set of one record at the top of both fields.
    send_record({IdW{1'b1}}, {TimeW{1'b1}}, 1'b1, 0);

    // Equal keys must keep their arrival order.
    send_record(IdW'(1), TimeW'(500), 1'b0, 0);
    send_record(IdW'(2), TimeW'(100), 1'b0, 0);
    send_record(IdW'(3), TimeW'(500), 1'b0, 0);
    send_record(IdW'(4), TimeW'(100), 1'b0, 0);
    send_record(IdW'(0), TimeW'(0), 1'b1, 0);

    // Full store in descending order; the closing record arrives when full and is dropped.
    for (int i = 0; i < MaxRecords; i++) begin
      send_record((i % 2 == 0) ? IdW'(10'h2AA) : IdW'(10'h155),
                  TimeW'(16'hFFFF - i * 16'h0FFF), 1'b0, 0);
    end
    send_record({IdW{1'b1}}, '0, 1'b1, 0);

    // Random sets under each idling pattern of the sender.
    foreach (idle_plan[p]) begin
      run_random_sets(32, idle_plan[p]);
    end
    start <= 1'b0;
    @(posedge clk_i);

    // Drain the remaining ranked records, then allow for any stray strobes.
    while (ranks.pending_ranks.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (ranks.mismatches == 0 && ranks.pending_ranks.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
